FILE: rtl/bcrc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcrc_pkg
// Shared constants and control types for the charge request controller.
// ----------------------------------------------------------------------------
package bcrc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_IMB_SET    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMB_CLEAR  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OV_SET     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OV_CLEAR   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_POWER      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TAPER      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FULL       = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT      = 3'd7;

    localparam logic [12:0] RST_IMB_SET   = 13'd100;
    localparam logic [12:0] RST_IMB_CLEAR = 13'd50;
    localparam logic [12:0] RST_OV_SET    = 13'd4250;
    localparam logic [12:0] RST_OV_CLEAR  = 13'd4150;
    localparam logic [14:0] RST_POWER     = 15'd6600;
    localparam logic [12:0] RST_TAPER     = 13'd4100;
    localparam logic [12:0] RST_FULL      = 13'd4200;
    localparam logic [12:0] RST_LIMIT     = 13'd100;

    localparam logic [13:0] CHARGE_VOLTAGE_DV = 14'd6000;
    localparam logic [14:0] PACK_MARGIN_DV    = 15'd100;
    localparam logic [12:0] CUR_MAX           = 13'd8191;

    localparam int DIVIDEND_W = 26;
    localparam int DIVISOR_W  = 15;
    localparam int DIV_CNT_W  = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'(DIVIDEND_W - 1);

    typedef struct packed {
        logic load_in;
        logic upd_flags;
        logic load_prod;
        logic setup;
        logic load_quot;
        logic load_out;
    } bcrc_cmd_t;

    typedef struct packed {
        logic connected;
        logic need_div;
        logic div_done;
    } bcrc_status_t;

endpackage
`default_nettype wire

FILE: rtl/bcrc_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcrc_divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcrc_divider (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [25:0] dividend,
    input  wire logic [14:0] divisor,
    output logic             done,
    output logic [25:0]      quotient
);
    import bcrc_pkg::*;

    logic                  active_reg, active_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W+1:0]  diff;

    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};

    always_comb begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        if (start) begin
            active_next = 1'b1;
            cnt_next    = '0;
            quo_next    = dividend;
            rem_next    = '0;
            dvs_next    = divisor;
        end else if (active_reg) begin
            if (!diff[DIVISOR_W+1]) begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST) begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

FILE: rtl/bcrc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcrc_datapath
// Configuration registers, hysteresis flags, current arithmetic and result.
// ----------------------------------------------------------------------------
module bcrc_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [14:0]         cfg_wdata,
    input  wire logic [7:0]          s_charger_status,
    input  wire logic [12:0]         s_max_cell_mv,
    input  wire logic [12:0]         s_min_cell_mv,
    input  wire logic [13:0]         s_pack_voltage_dv,
    input  wire bcrc_pkg::bcrc_cmd_t cmd,
    output bcrc_pkg::bcrc_status_t   status,
    output logic [13:0]              m_voltage_request_dv,
    output logic [12:0]              m_current_request_da,
    output logic                     m_charge_allowed
);
    import bcrc_pkg::*;

    logic [12:0] imb_set_reg, imb_clr_reg, ov_set_reg, ov_clr_reg;
    logic [14:0] power_reg;
    logic [12:0] taper_reg, full_reg, limit_reg;

    logic        conn_reg, imb_flag_reg, ov_flag_reg;
    logic [12:0] max_reg, min_reg;
    logic [13:0] pack_reg;
    logic [27:0] prod_reg;
    logic [12:0] cur_reg, cur_next;
    logic [13:0] out_v_reg;
    logic [12:0] out_i_reg;
    logic        out_a_reg;

    logic signed [13:0] imb, num, den;
    logic [13:0]        num_neg, den_neg;
    logic [12:0]        abs_num, abs_den;
    logic               sign_mis, den_zero, taper_sel, allowed;
    logic [14:0]        div_sum, mul_b;
    logic [21:0]        pnum;
    logic [27:0]        prod_next;
    logic [25:0]        dividend, quotient;
    logic [14:0]        divisor;
    logic               need_div, div_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            imb_set_reg <= RST_IMB_SET;
            imb_clr_reg <= RST_IMB_CLEAR;
            ov_set_reg  <= RST_OV_SET;
            ov_clr_reg  <= RST_OV_CLEAR;
            power_reg   <= RST_POWER;
            taper_reg   <= RST_TAPER;
            full_reg    <= RST_FULL;
            limit_reg   <= RST_LIMIT;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_IMB_SET:   imb_set_reg <= cfg_wdata[12:0];
                REG_IMB_CLEAR: imb_clr_reg <= cfg_wdata[12:0];
                REG_OV_SET:    ov_set_reg  <= cfg_wdata[12:0];
                REG_OV_CLEAR:  ov_clr_reg  <= cfg_wdata[12:0];
                REG_POWER:     power_reg   <= cfg_wdata;
                REG_TAPER:     taper_reg   <= cfg_wdata[12:0];
                REG_FULL:      full_reg    <= cfg_wdata[12:0];
                REG_LIMIT:     limit_reg   <= cfg_wdata[12:0];
                default: begin
                end
            endcase
        end
    end

    assign imb       = $signed({1'b0, max_reg}) - $signed({1'b0, min_reg});
    assign num       = $signed({1'b0, full_reg}) - $signed({1'b0, max_reg});
    assign den       = $signed({1'b0, full_reg}) - $signed({1'b0, taper_reg});
    assign num_neg   = -num;
    assign den_neg   = -den;
    assign abs_num   = num[13] ? num_neg[12:0] : num[12:0];
    assign abs_den   = den[13] ? den_neg[12:0] : den[12:0];
    assign sign_mis  = num[13] != den[13];
    assign den_zero  = den == 14'sd0;
    assign taper_sel = max_reg > taper_reg;
    assign allowed   = !(imb_flag_reg || ov_flag_reg);

    assign div_sum   = {1'b0, pack_reg} + PACK_MARGIN_DV;
    assign mul_b     = taper_sel ? {2'b00, abs_num} : div_sum;
    assign prod_next = 28'(limit_reg) * 28'(mul_b);
    assign pnum      = 22'(power_reg) * 22'd100;

    always_comb begin
        if (!allowed) begin
            need_div = 1'b0;
        end else if (taper_sel) begin
            need_div = !den_zero && !sign_mis;
        end else begin
            need_div = prod_reg > 28'(pnum);
        end
    end

    assign dividend = taper_sel ? prod_reg[25:0] : 26'(pnum);
    assign divisor  = taper_sel ? {2'b00, abs_den} : div_sum;

    bcrc_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.setup && need_div),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        cur_next = cur_reg;
        if (cmd.setup) begin
            if (!allowed) begin
                cur_next = '0;
            end else if (taper_sel && !den_zero) begin
                cur_next = '0;
            end else begin
                cur_next = limit_reg;
            end
        end else if (cmd.load_quot) begin
            cur_next = (quotient > 26'(CUR_MAX)) ? CUR_MAX : quotient[12:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conn_reg     <= 1'b0;
            imb_flag_reg <= 1'b0;
            ov_flag_reg  <= 1'b0;
        end else begin
            if (cmd.load_in && s_charger_status != 8'd0) begin
                conn_reg <= 1'b1;
            end
            if (cmd.upd_flags) begin
                if (imb > $signed({1'b0, imb_set_reg})) begin
                    imb_flag_reg <= 1'b1;
                end else if (imb < $signed({1'b0, imb_clr_reg})) begin
                    imb_flag_reg <= 1'b0;
                end
                if (max_reg > ov_set_reg) begin
                    ov_flag_reg <= 1'b1;
                end else if (max_reg < ov_clr_reg) begin
                    ov_flag_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            max_reg  <= s_max_cell_mv;
            min_reg  <= s_min_cell_mv;
            pack_reg <= s_pack_voltage_dv;
        end
        if (cmd.load_prod) begin
            prod_reg <= prod_next;
        end
        cur_reg <= cur_next;
        if (cmd.load_out) begin
            out_v_reg <= allowed ? CHARGE_VOLTAGE_DV : 14'd0;
            out_i_reg <= cur_reg;
            out_a_reg <= allowed;
        end
    end

    assign status.connected = conn_reg;
    assign status.need_div  = need_div;
    assign status.div_done  = div_done;

    assign m_voltage_request_dv = out_v_reg;
    assign m_current_request_da = out_i_reg;
    assign m_charge_allowed     = out_a_reg;

endmodule
`default_nettype wire

FILE: rtl/bcrc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcrc_ctrl
// Sequencer for one evaluation tick and the result beat valid flag.
// ----------------------------------------------------------------------------
module bcrc_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    input  wire bcrc_pkg::bcrc_status_t status,
    output bcrc_pkg::bcrc_cmd_t         cmd
);
    import bcrc_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_FLAGS  = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_SETUP  = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_RESULT = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg && !m_ready;
        cmd         = '0;
        s_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = status.connected ? ST_FLAGS : ST_IDLE;
            end
            ST_FLAGS: begin
                cmd.upd_flags = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL: begin
                cmd.load_prod = 1'b1;
                state_next    = ST_SETUP;
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = status.need_div ? ST_DIV : ST_RESULT;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    cmd.load_quot = 1'b1;
                    state_next    = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!mvalid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_valid = mvalid_reg;

endmodule
`default_nettype wire

FILE: rtl/battery_charge_request_control.sv
`default_nettype none
// ----------------------------------------------------------------------------
// battery_charge_request_control
// Charge voltage and current request with hysteresis and current taper.
// ----------------------------------------------------------------------------
// Each input beat is one evaluation tick with the charger status byte and the
// cell and pack measurements. A nonzero status byte latches the connected
// state; ticks before that produce no result beat. A connected tick produces
// exactly one result beat with the voltage and current requests.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user
// must write it only while the block is idle, which the block itself does not
// enforce, and a write takes effect at once. Ticks are taken one at a time:
// the next tick is accepted in the cycle after the result is loaded, or after
// the check state when the tick is not connected. A needed division is done by
// the 26-step restoring divider.
// The result sits in an output register; a stalled receiver does not block
// the next input beat, which is processed until its own result is ready.
// Reset clears the connected latch, both flags and loads register defaults.
// ----------------------------------------------------------------------------
module battery_charge_request_control (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [14:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_charger_status,
    input  wire logic [12:0] s_max_cell_mv,
    input  wire logic [12:0] s_min_cell_mv,
    input  wire logic [13:0] s_pack_voltage_dv,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [13:0]      m_voltage_request_dv,
    output logic [12:0]      m_current_request_da,
    output logic             m_charge_allowed
);
    import bcrc_pkg::*;

    bcrc_cmd_t    cmd;
    bcrc_status_t status;

    bcrc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bcrc_datapath u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_charger_status     (s_charger_status),
        .s_max_cell_mv        (s_max_cell_mv),
        .s_min_cell_mv        (s_min_cell_mv),
        .s_pack_voltage_dv    (s_pack_voltage_dv),
        .cmd                  (cmd),
        .status               (status),
        .m_voltage_request_dv (m_voltage_request_dv),
        .m_current_request_da (m_current_request_da),
        .m_charge_allowed     (m_charge_allowed)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_charge_allowed) |->
            (m_voltage_request_dv == 14'd0 && m_current_request_da == 13'd0))
        else $error("disallowed result carries a nonzero request");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_charge_allowed) |-> (m_voltage_request_dv == CHARGE_VOLTAGE_DV))
        else $error("allowed result carries a wrong voltage request");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a tick is still in progress");

endmodule
`default_nettype wire

FILE: sim/battery_charge_request_control_test.sv
// ----------------------------------------------------------------------------
// battery_charge_request_control_test
// Self-checking testbench for the charge request controller.
// ----------------------------------------------------------------------------
// A short table of ticks walks the block from the unplugged state through the
// imbalance and overvoltage hysteresis bands and the taper region. The block
// is then run through several register settings with random ticks. Most of
// these ticks sit near the active thresholds, and a few use raw bit patterns.
// Every accepted tick goes through a local model of the controller, and each
// result beat is compared field by field with the oldest prediction. Both
// sides idle at random. The receiver also holds off once for a long stretch
// so that the block stalls its input.
// ----------------------------------------------------------------------------
module battery_charge_request_control_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bcrc_pkg::*;

    localparam int ITEMS_PER_PHASE = 70;
    localparam int NUM_PHASES      = 7;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_AFTER      = 150;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef struct packed {
        logic [7:0]  status;
        logic [12:0] max_mv;
        logic [12:0] min_mv;
        logic [13:0] pack_dv;
    } tick_t;

    typedef struct packed {
        logic [13:0] volt_dv;
        logic [12:0] curr_da;
        logic        allowed;
    } request_t;

    typedef struct {
        tick_t    tick;
        bit       typed;
        bit       yields;
        request_t req;
    } row_t;

    localparam request_t REQ_OFF     = '{14'd0, 13'd0, 1'b0};
    localparam request_t REQ_DEFAULT = '{CHARGE_VOLTAGE_DV, RST_LIMIT, 1'b1};

    row_t directed_rows [19] = '{
        '{'{8'h00, 13'd3700, 13'd3690, 14'd5000},  1'b1, 1'b0, REQ_OFF},
        '{'{8'h00, 13'd8191, 13'd0,    14'd16383}, 1'b1, 1'b0, REQ_OFF},
        '{'{8'h01, 13'd3700, 13'd3690, 14'd0},     1'b1, 1'b1, REQ_DEFAULT},
        '{'{8'h00, 13'd3700, 13'd3700, 14'd16383}, 1'b0, 1'b1, REQ_OFF},
        '{'{8'hFF, 13'd3800, 13'd3600, 14'd2000},  1'b1, 1'b1, REQ_OFF},
        '{'{8'h5A, 13'd3800, 13'd3725, 14'd2000},  1'b1, 1'b1, REQ_OFF},
        '{'{8'hA5, 13'd3800, 13'd3760, 14'd3000},  1'b0, 1'b1, REQ_OFF},
        '{'{8'h00, 13'd4000, 13'd3000, 14'd3000},  1'b1, 1'b1, REQ_OFF},
        '{'{8'h00, 13'd3000, 13'd4000, 14'd3000},  1'b0, 1'b1, REQ_OFF},
        '{'{8'h00, 13'd4300, 13'd4300, 14'd3000},  1'b1, 1'b1, REQ_OFF},
        '{'{8'h00, 13'd4200, 13'd4200, 14'd3000},  1'b1, 1'b1, REQ_OFF},
        '{'{8'h00, 13'd4140, 13'd4140, 14'd1000},  1'b0, 1'b1, REQ_OFF},
        '{'{8'h00, 13'd4100, 13'd4100, 14'd0},     1'b1, 1'b1, REQ_DEFAULT},
        '{'{8'h00, 13'd4101, 13'd4101, 14'd0},     1'b0, 1'b1, REQ_OFF},
        '{'{8'h00, 13'd4210, 13'd4210, 14'd0},     1'b0, 1'b1, REQ_OFF},
        '{'{8'h00, 13'd8191, 13'd8191, 14'd0},     1'b1, 1'b1, REQ_OFF},
        '{'{8'h00, 13'd0,    13'd8191, 14'd16383}, 1'b0, 1'b1, REQ_OFF},
        '{'{8'h00, 13'd0,    13'd0,    14'd0},     1'b1, 1'b1, REQ_DEFAULT},
        '{'{8'h00, 13'd5000, 13'd0,    14'd10000}, 1'b1, 1'b1, REQ_OFF}
    };

    logic        aclk;
    logic        aresetn           = 1'b0;
    logic        cfg_we            = 1'b0;
    logic [2:0]  cfg_index         = '0;
    logic [14:0] cfg_wdata         = '0;
    logic        s_valid           = 1'b0;
    logic        s_ready;
    logic [7:0]  s_charger_status  = '0;
    logic [12:0] s_max_cell_mv     = '0;
    logic [12:0] s_min_cell_mv     = '0;
    logic [13:0] s_pack_voltage_dv = '0;
    logic        m_valid;
    logic        m_ready           = 1'b0;
    logic [13:0] m_voltage_request_dv;
    logic [12:0] m_current_request_da;
    logic        m_charge_allowed;

    // Typed expectation that travels with the tick on the input channel.
    bit       row_typed  = 1'b0;
    bit       row_yields = 1'b0;
    request_t row_req    = REQ_OFF;

    logic [14:0] model_cfg [8];
    logic [14:0] phase_cfg [8];
    bit          plugged_in;
    bit          imb_latched;
    bit          ov_latched;

    request_t pending_requests [$];
    int       ticks_sent;
    int       requests_seen;
    int       mismatch_count;
    int       quiet_cycles;
    bit       no_idle;

    battery_charge_request_control dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_charger_status     (s_charger_status),
        .s_max_cell_mv        (s_max_cell_mv),
        .s_min_cell_mv        (s_min_cell_mv),
        .s_pack_voltage_dv    (s_pack_voltage_dv),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_voltage_request_dv (m_voltage_request_dv),
        .m_current_request_da (m_current_request_da),
        .m_charge_allowed     (m_charge_allowed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic evaluate_tick(input tick_t t, output bit yields, output request_t r);
        longint maxc, imb, lim, div, pnum, num, den, q;
        longint taper, full;
        r = REQ_OFF;
        yields = 1'b0;
        if (t.status != 8'h00) begin
            plugged_in = 1'b1;
        end
        if (!plugged_in) begin
            return;
        end
        yields = 1'b1;
        maxc  = t.max_mv;
        imb   = maxc - longint'(t.min_mv);
        taper = model_cfg[REG_TAPER];
        full  = model_cfg[REG_FULL];
        if (imb > longint'(model_cfg[REG_IMB_SET])) begin
            imb_latched = 1'b1;
        end else if (imb < longint'(model_cfg[REG_IMB_CLEAR])) begin
            imb_latched = 1'b0;
        end
        if (maxc > longint'(model_cfg[REG_OV_SET])) begin
            ov_latched = 1'b1;
        end else if (maxc < longint'(model_cfg[REG_OV_CLEAR])) begin
            ov_latched = 1'b0;
        end
        r.allowed = !(imb_latched || ov_latched);
        if (r.allowed) begin
            lim  = model_cfg[REG_LIMIT];
            div  = longint'(t.pack_dv) + longint'(PACK_MARGIN_DV);
            pnum = 100 * longint'(model_cfg[REG_POWER]);
            r.volt_dv = CHARGE_VOLTAGE_DV;
            q = lim;
            if (div != 0 && lim * div > pnum) begin
                q = pnum / div;
            end
            if (maxc > taper) begin
                num = full - maxc;
                den = full - taper;
                if (den == 0) begin
                    q = lim;
                end else if ((num < 0) != (den < 0)) begin
                    q = 0;
                end else begin
                    if (num < 0) begin
                        num = -num;
                        den = -den;
                    end
                    q = lim * num / den;
                    if (q > longint'(CUR_MAX)) begin
                        q = longint'(CUR_MAX);
                    end
                end
            end
            r.curr_da = q[12:0];
        end
    endtask

    function automatic int clamp_mv(input int v);
        return (v < 0) ? 0 : (v > 8191) ? 8191 : v;
    endfunction

    function automatic tick_t draw_tick();
        tick_t t;
        int    anchor, spread, hi;
        t.status  = 8'($urandom);
        t.pack_dv = 14'($urandom_range(0, 10000));
        if ($urandom_range(0, 9) == 0) begin
            t.max_mv  = 13'($urandom);
            t.min_mv  = 13'($urandom);
            t.pack_dv = 14'($urandom);
        end else begin
            case ($urandom_range(0, 3))
                0: anchor = model_cfg[REG_OV_SET];
                1: anchor = model_cfg[REG_OV_CLEAR];
                2: anchor = model_cfg[REG_TAPER];
                default: anchor = model_cfg[REG_FULL];
            endcase
            spread = $urandom_range(0, 1) ? model_cfg[REG_IMB_SET] : model_cfg[REG_IMB_CLEAR];
            hi = clamp_mv(anchor + int'($urandom_range(0, 120)) - 60);
            t.max_mv = 13'(hi);
            t.min_mv = 13'(clamp_mv(hi - (spread + int'($urandom_range(0, 60)) - 30)));
        end
        return t;
    endfunction

    task automatic send_tick(input tick_t t, input bit typed, input bit yields,
                             input request_t req);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_charger_status  <= t.status;
        s_max_cell_mv     <= t.max_mv;
        s_min_cell_mv     <= t.min_mv;
        s_pack_voltage_dv <= t.pack_dv;
        row_typed         <= typed;
        row_yields        <= yields;
        row_req           <= req;
        do @(posedge aclk); while (!s_ready);
        ticks_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_requests.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config();
        foreach (phase_cfg[r]) begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(r);
            cfg_wdata <= phase_cfg[r];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic void compare_field(input string name, input logic [13:0] want,
                                          input logic [13:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : scoreboard
        bit       yields;
        request_t predicted;
        request_t want;
        if (aresetn) begin
            if (cfg_we) begin
                model_cfg[cfg_index] = cfg_wdata & ((cfg_index == REG_POWER) ? 15'h7FFF : 15'h1FFF);
            end
            if (s_valid && s_ready) begin
                evaluate_tick({s_charger_status, s_max_cell_mv, s_min_cell_mv, s_pack_voltage_dv},
                              yields, predicted);
                if (row_typed) begin
                    yields    = row_yields;
                    predicted = row_req;
                end
                if (yields) begin
                    pending_requests.push_back(predicted);
                end
            end
            if (m_valid && m_ready) begin
                requests_seen++;
                if (pending_requests.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: request beat with nothing expected, got %0d/%0d/%0d",
                             $time, m_voltage_request_dv, m_current_request_da, m_charge_allowed);
                end else begin
                    want = pending_requests.pop_front();
                    compare_field("voltage_request_dv", want.volt_dv, m_voltage_request_dv);
                    compare_field("current_request_da", 14'(want.curr_da), 14'(m_current_request_da));
                    compare_field("charge_allowed", 14'(want.allowed), 14'(m_charge_allowed));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t ns: no beat moved for %0d cycles", $time, quiet_cycles);
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    initial begin : result_sink
        int stall;
        bit held;
        held = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!held && requests_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin : stimulus
        model_cfg = '{RST_IMB_SET, RST_IMB_CLEAR, RST_OV_SET, RST_OV_CLEAR,
                      RST_POWER, RST_TAPER, RST_FULL, RST_LIMIT};
        plugged_in     = 1'b0;
        imb_latched    = 1'b0;
        ov_latched     = 1'b0;
        ticks_sent     = 0;
        requests_seen  = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        no_idle        = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_tick(directed_rows[i].tick, directed_rows[i].typed,
                      directed_rows[i].yields, directed_rows[i].req);
        end

        for (int p = 1; p <= NUM_PHASES; p++) begin
            wait_idle();
            case (p)
                1: phase_cfg = '{15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0};
                2: phase_cfg = '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF,
                                 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF};
                3: phase_cfg = '{15'd150, 15'd40, 15'd4300, 15'd4000,
                                 15'd20000, 15'd4000, 15'd4000, 15'd5000};
                4: phase_cfg = '{15'd200, 15'd100, 15'd4400, 15'd4200,
                                 15'd9000, 15'd4000, 15'd3990, 15'd5000};
                7: phase_cfg = '{15'(RST_IMB_SET), 15'(RST_IMB_CLEAR), 15'(RST_OV_SET),
                                 15'(RST_OV_CLEAR), RST_POWER, 15'(RST_TAPER),
                                 15'(RST_FULL), 15'(RST_LIMIT)};
                default: begin
                    foreach (phase_cfg[r]) begin
                        phase_cfg[r] = (r == REG_POWER) ? 15'($urandom_range(0, 20000))
                                                        : 15'($urandom_range(0, 5000));
                    end
                end
            endcase
            write_config();
            no_idle = (p == 2 || p == 5);
            repeat (ITEMS_PER_PHASE) begin
                send_tick(draw_tick(), 1'b0, 1'b0, REQ_OFF);
            end
        end
        wait_idle();

        $display("Sent %0d ticks and checked %0d request beats over %0d register settings.",
                 ticks_sent, requests_seen, NUM_PHASES + 1);
        $display("Covered unplugged ticks, both hysteresis bands, taper limits and output stalls.");
        if (mismatch_count == 0 && pending_requests.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
